// File: design/mer_pkg.sv
package mer_pkg;

    // Codes carried in the slave tuser bit.
    localparam logic ACT_LOAD = 1'b0;
    localparam logic ACT_STEP = 1'b1;

    // Drawing phase of the current ellipse.
    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_R1   = 2'd1,
        PH_R2   = 2'd2
    } t_phase;

    // Operand pairs of the shared multiplier.
    typedef enum logic [2:0] {
        MUL_A_A   = 3'd0,
        MUL_B_B   = 3'd1,
        MUL_A2_B  = 3'd2,
        MUL_TX_TX = 3'd3,
        MUL_B2_P  = 3'd4,
        MUL_YM_YM = 3'd5,
        MUL_A2_P  = 3'd6,
        MUL_A2_B2 = 3'd7
    } t_mul_sel;

    // Controller states.
    typedef enum logic [3:0] {
        S_IDLE   = 4'd0,
        S_LD_AA  = 4'd1,
        S_LD_BB  = 4'd2,
        S_LD_AB  = 4'd3,
        S_LD_FIN = 4'd4,
        S_SW_TT  = 4'd5,
        S_SW_BT  = 4'd6,
        S_SW_YY  = 4'd7,
        S_SW_AY  = 4'd8,
        S_SW_AB  = 4'd9,
        S_SW_FIN = 4'd10,
        S_STEP   = 4'd11
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic     capture;
        logic     zero_out;
        logic     step;
        logic     ld_a2;
        logic     ld_b2;
        logic     ld_r1;
        logic     acc_init;
        logic     acc_add;
        logic     sw_fin;
        t_mul_sel mul_sel;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        t_phase phase;
        logic   need_switch;
        logic   out_free;
    } t_status;

endpackage

// File: design/mer_ctrl.sv
module mer_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_s_tvalid,
    input  logic            i_action,
    input  mer_pkg::t_status i_status,
    output logic            o_s_tready,
    output mer_pkg::t_cmd   o_cmd
);
    import mer_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   accept;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // A word is taken only in the idle state, where ready follows the output register.
    assign accept = i_s_tvalid && i_status.out_free;

    // Next state and commands.
    always_comb begin
        n_state       = r_state;
        o_s_tready    = 1'b0;
        o_cmd         = '0;
        o_cmd.mul_sel = MUL_A_A;
        case (r_state)
            S_IDLE: begin
                o_s_tready = i_status.out_free;
                if (accept) begin
                    if (i_action == ACT_LOAD) begin
                        o_cmd.capture  = 1'b1;
                        o_cmd.zero_out = 1'b1;
                        n_state        = S_LD_AA;
                    end else if (i_status.phase == PH_R1 && i_status.need_switch) begin
                        n_state = S_SW_TT;
                    end else if (i_status.phase == PH_R1 || i_status.phase == PH_R2) begin
                        o_cmd.step = 1'b1;
                    end else begin
                        o_cmd.zero_out = 1'b1;
                    end
                end
            end
            S_LD_AA: begin
                o_cmd.mul_sel = MUL_A_A;
                n_state       = S_LD_BB;
            end
            S_LD_BB: begin
                o_cmd.mul_sel = MUL_B_B;
                o_cmd.ld_a2   = 1'b1;
                n_state       = S_LD_AB;
            end
            S_LD_AB: begin
                o_cmd.mul_sel = MUL_A2_B;
                o_cmd.ld_b2   = 1'b1;
                n_state       = S_LD_FIN;
            end
            S_LD_FIN: begin
                o_cmd.ld_r1 = 1'b1;
                n_state     = S_IDLE;
            end
            S_SW_TT: begin
                o_cmd.mul_sel = MUL_TX_TX;
                n_state       = S_SW_BT;
            end
            S_SW_BT: begin
                o_cmd.mul_sel = MUL_B2_P;
                n_state       = S_SW_YY;
            end
            S_SW_YY: begin
                o_cmd.mul_sel  = MUL_YM_YM;
                o_cmd.acc_init = 1'b1;
                n_state        = S_SW_AY;
            end
            S_SW_AY: begin
                o_cmd.mul_sel = MUL_A2_P;
                n_state       = S_SW_AB;
            end
            S_SW_AB: begin
                o_cmd.mul_sel = MUL_A2_B2;
                o_cmd.acc_add = 1'b1;
                n_state       = S_SW_FIN;
            end
            S_SW_FIN: begin
                o_cmd.sw_fin = 1'b1;
                n_state      = S_STEP;
            end
            S_STEP: begin
                o_cmd.step = 1'b1;
                n_state    = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// File: design/mer_dp.sv
module mer_dp #(
    parameter int AXIS_BITS  = 10,
    parameter int COORD_BITS = 12
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  mer_pkg::t_cmd                 i_cmd,
    input  logic signed [COORD_BITS-1:0]  i_center_x,
    input  logic signed [COORD_BITS-1:0]  i_center_y,
    input  logic [AXIS_BITS-1:0]          i_semi_axis_x,
    input  logic [AXIS_BITS-1:0]          i_semi_axis_y,
    input  logic                          i_m_tready,
    output mer_pkg::t_status              o_status,
    output logic                          o_out_valid,
    output logic [4*(COORD_BITS+1)-1:0]   o_out_coords,
    output logic                          o_out_valid_res,
    output logic                          o_out_last
);
    import mer_pkg::*;

    localparam int XW = AXIS_BITS + 1;
    localparam int SW = 3 * AXIS_BITS + 2;
    localparam int DW = 4 * AXIS_BITS + 6;
    localparam int MW = 2 * AXIS_BITS + 4;
    localparam int PW = 2 * MW;
    localparam int OW = COORD_BITS + 1;
    localparam int EW = COORD_BITS + AXIS_BITS + 2;
    localparam int QW = 2 * AXIS_BITS;

    logic signed [COORD_BITS-1:0] r_cx, n_cx, r_cy, n_cy;
    logic [AXIS_BITS-1:0]         r_a, n_a, r_b, n_b;
    logic [QW-1:0]                r_a2, n_a2, r_b2, n_b2;
    logic [XW-1:0]                r_x, n_x, r_y, n_y;
    logic [SW-1:0]                r_stx, n_stx, r_sty, n_sty;
    logic signed [DW-1:0]         r_dec, n_dec, r_acc, n_acc;
    logic [PW-1:0]                r_prod;
    t_phase                       r_phase, n_phase;
    logic                         r_out_valid;
    logic [4*OW-1:0]              r_out_coords, n_out_coords;
    logic                         r_out_res, n_out_res;
    logic                         r_out_last, n_out_last;

    logic [MW-1:0]        mul_a, mul_b;
    logic [XW:0]          tx;
    logic [XW-1:0]        ym;
    logic signed [DW-1:0] a2_s, b2_s, prod_s, stx_inc_s, sty_dec_s;
    logic [SW-1:0]        stx_inc, sty_dec;
    logic [EW-1:0]        sum_r, sum_l, sum_lo, sum_up;

    // Shared multiplier operand select.
    assign tx = {r_x, 1'b1};
    assign ym = (r_y == '0) ? XW'(1) : r_y - XW'(1);

    always_comb begin
        case (i_cmd.mul_sel)
            MUL_A_A: begin
                mul_a = MW'(r_a);
                mul_b = MW'(r_a);
            end
            MUL_B_B: begin
                mul_a = MW'(r_b);
                mul_b = MW'(r_b);
            end
            MUL_A2_B: begin
                mul_a = MW'(r_a2);
                mul_b = MW'(r_b);
            end
            MUL_TX_TX: begin
                mul_a = MW'(tx);
                mul_b = MW'(tx);
            end
            MUL_B2_P: begin
                mul_a = MW'(r_b2);
                mul_b = r_prod[MW-1:0];
            end
            MUL_YM_YM: begin
                mul_a = MW'(ym);
                mul_b = MW'(ym);
            end
            MUL_A2_P: begin
                mul_a = MW'(r_a2);
                mul_b = r_prod[MW-1:0];
            end
            MUL_A2_B2: begin
                mul_a = MW'(r_a2);
                mul_b = MW'(r_b2);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // Signed views of the stored terms and the step increments.
    assign a2_s      = DW'(r_a2);
    assign b2_s      = DW'(r_b2);
    assign prod_s    = DW'(r_prod);
    assign stx_inc   = r_stx + SW'({r_b2, 1'b0});
    assign sty_dec   = r_sty - SW'({r_a2, 1'b0});
    assign stx_inc_s = DW'(stx_inc);
    assign sty_dec_s = DW'(sty_dec);

    // Mirrored coordinates, wrapped to the output width.
    assign sum_r  = EW'(r_cx) + EW'(r_x);
    assign sum_l  = EW'(r_cx) - EW'(r_x);
    assign sum_lo = EW'(r_cy) + EW'(r_y);
    assign sum_up = EW'(r_cy) - EW'(r_y);

    // Next-state logic for the drawing state and the output word.
    always_comb begin
        n_cx         = r_cx;
        n_cy         = r_cy;
        n_a          = r_a;
        n_b          = r_b;
        n_a2         = r_a2;
        n_b2         = r_b2;
        n_x          = r_x;
        n_y          = r_y;
        n_stx        = r_stx;
        n_sty        = r_sty;
        n_dec        = r_dec;
        n_acc        = r_acc;
        n_phase      = r_phase;
        n_out_coords = r_out_coords;
        n_out_res    = r_out_res;
        n_out_last   = r_out_last;

        if (i_cmd.capture) begin
            n_cx = i_center_x;
            n_cy = i_center_y;
            n_a  = i_semi_axis_x;
            n_b  = i_semi_axis_y;
        end
        if (i_cmd.ld_a2) begin
            n_a2 = r_prod[QW-1:0];
        end
        if (i_cmd.ld_b2) begin
            n_b2 = r_prod[QW-1:0];
        end
        // Region 1 start point and decision value.
        if (i_cmd.ld_r1) begin
            n_x     = '0;
            n_y     = XW'(r_b);
            n_stx   = '0;
            n_sty   = {r_prod[SW-2:0], 1'b0};
            n_dec   = (b2_s <<< 2) - (prod_s <<< 2) + a2_s;
            n_phase = PH_R1;
        end
        // Region 2 decision value built up over the multiply chain.
        if (i_cmd.acc_init) begin
            n_acc = prod_s;
        end
        if (i_cmd.acc_add) begin
            n_acc = r_acc + (prod_s <<< 2);
        end
        if (i_cmd.sw_fin) begin
            n_dec   = r_acc - (prod_s <<< 2);
            n_phase = PH_R2;
        end

        if (i_cmd.zero_out) begin
            n_out_coords = '0;
            n_out_res    = 1'b0;
            n_out_last   = 1'b0;
        end

        // Emit the current point, then advance by the midpoint rule.
        if (i_cmd.step) begin
            n_out_coords = {sum_up[OW-1:0], sum_lo[OW-1:0], sum_l[OW-1:0], sum_r[OW-1:0]};
            n_out_res    = 1'b1;
            n_out_last   = 1'b0;
            if (r_phase == PH_R1) begin
                n_x   = r_x + XW'(1);
                n_stx = stx_inc;
                if (r_dec < 0) begin
                    n_dec = r_dec + ((stx_inc_s + b2_s) <<< 2);
                end else begin
                    n_y   = r_y - XW'(1);
                    n_sty = sty_dec;
                    n_dec = r_dec + ((stx_inc_s - sty_dec_s + b2_s) <<< 2);
                end
            end else if (r_y == '0) begin
                n_out_last = 1'b1;
                n_phase    = PH_IDLE;
            end else begin
                n_y   = r_y - XW'(1);
                n_sty = sty_dec;
                if (r_dec > 0) begin
                    n_dec = r_dec + ((a2_s - sty_dec_s) <<< 2);
                end else begin
                    n_x   = r_x + XW'(1);
                    n_stx = stx_inc;
                    n_dec = r_dec + ((stx_inc_s - sty_dec_s + a2_s) <<< 2);
                end
            end
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_phase <= n_phase;
            if (i_cmd.step || i_cmd.zero_out) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_cx         <= n_cx;
        r_cy         <= n_cy;
        r_a          <= n_a;
        r_b          <= n_b;
        r_a2         <= n_a2;
        r_b2         <= n_b2;
        r_x          <= n_x;
        r_y          <= n_y;
        r_stx        <= n_stx;
        r_sty        <= n_sty;
        r_dec        <= n_dec;
        r_acc        <= n_acc;
        r_prod       <= mul_a * mul_b;
        r_out_coords <= n_out_coords;
        r_out_res    <= n_out_res;
        r_out_last   <= n_out_last;
    end

    // Status back to the controller.
    assign o_status.phase       = r_phase;
    assign o_status.need_switch = (r_stx >= r_sty);
    assign o_status.out_free    = !r_out_valid || i_m_tready;

    assign o_out_valid     = r_out_valid;
    assign o_out_coords    = r_out_coords;
    assign o_out_valid_res = r_out_res;
    assign o_out_last      = r_out_last;

endmodule

// File: design/midpoint_ellipse_rasterizer_unit.sv
// A step word gives its result word in the cycle after it is taken; the step that leaves
// region 1 first runs a five-product chain on the shared multiplier, then steps (S_STEP).
// Throughput: one step word per cycle while each result word is taken; a load word busies
// the block (three chained products on the same multiplier), as does a region switch.
// Reset (i_rst_n low, synchronous) leaves the block idle with no result word pending.
module midpoint_ellipse_rasterizer_unit #(
    parameter int AXIS_BITS  = 10,
    parameter int COORD_BITS = 12,
    localparam int IN_DW     = ((2 * COORD_BITS + 2 * AXIS_BITS + 7) / 8) * 8,
    localparam int OUT_DW    = ((4 * (COORD_BITS + 1) + 7) / 8) * 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_tvalid,
    output logic              o_s_tready,
    // center_x, center_y, semi_axis_x, semi_axis_y
    input  logic [IN_DW-1:0]  i_s_tdata,
    // action
    input  logic              i_s_tuser,
    output logic              o_m_tvalid,
    input  logic              i_m_tready,
    // right_col, left_col, lower_row, upper_row
    output logic [OUT_DW-1:0] o_m_tdata,
    // valid_res
    output logic              o_m_tuser,
    output logic              o_m_tlast
);
    import mer_pkg::*;

    localparam int OW = COORD_BITS + 1;

    t_cmd                         cmd;
    t_status                      status;
    logic signed [COORD_BITS-1:0] center_x, center_y;
    logic [AXIS_BITS-1:0]         semi_axis_x, semi_axis_y;
    logic [4*OW-1:0]              out_coords;

    // Unpack the input word.
    assign center_x    = i_s_tdata[COORD_BITS-1:0];
    assign center_y    = i_s_tdata[2*COORD_BITS-1:COORD_BITS];
    assign semi_axis_x = i_s_tdata[2*COORD_BITS+AXIS_BITS-1:2*COORD_BITS];
    assign semi_axis_y = i_s_tdata[2*COORD_BITS+2*AXIS_BITS-1:2*COORD_BITS+AXIS_BITS];

    mer_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .i_action   (i_s_tuser),
        .i_status   (status),
        .o_s_tready (o_s_tready),
        .o_cmd      (cmd)
    );

    mer_dp #(
        .AXIS_BITS  (AXIS_BITS),
        .COORD_BITS (COORD_BITS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .i_center_x      (center_x),
        .i_center_y      (center_y),
        .i_semi_axis_x   (semi_axis_x),
        .i_semi_axis_y   (semi_axis_y),
        .i_m_tready      (i_m_tready),
        .o_status        (status),
        .o_out_valid     (o_m_tvalid),
        .o_out_coords    (out_coords),
        .o_out_valid_res (o_m_tuser),
        .o_out_last      (o_m_tlast)
    );

    // Pack the result word, zero filled to whole bytes.
    assign o_m_tdata = OUT_DW'(out_coords);

endmodule

// File: dv/midpoint_ellipse_rasterizer_unit_tb.sv
module midpoint_ellipse_rasterizer_unit_tb;

    import mer_pkg::*;

    localparam int AXIS_W      = 10;
    localparam int COORD_W     = 12;
    localparam int IN_W        = ((2 * COORD_W + 2 * AXIS_W + 7) / 8) * 8;
    localparam int OUT_W       = ((4 * (COORD_W + 1) + 7) / 8) * 8;
    localparam int STALL_LIMIT = 2000;
    localparam int HOLD_CYCLES = 300;
    localparam int RAND_WORDS  = 1600;

    // One input word as the sender sees it.
    typedef struct {
        logic               action;
        logic [COORD_W-1:0] cx;
        logic [COORD_W-1:0] cy;
        logic [AXIS_W-1:0]  a;
        logic [AXIS_W-1:0]  b;
        bit                 drain;
    } t_word;

    // One plotted point as the block reports it.
    typedef struct {
        logic [12:0] right_col;
        logic [12:0] left_col;
        logic [12:0] lower_row;
        logic [12:0] upper_row;
        logic        valid_res;
        logic        last;
    } t_point;

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             i_s_tvalid = 1'b0;
    logic             o_s_tready;
    // center_x, center_y, semi_axis_x, semi_axis_y
    logic [IN_W-1:0]  i_s_tdata = '0;
    // action
    logic             i_s_tuser = 1'b0;
    logic             o_m_tvalid;
    logic             i_m_tready = 1'b0;
    // right_col, left_col, lower_row, upper_row
    logic [OUT_W-1:0] o_m_tdata;
    // valid_res
    logic             o_m_tuser;
    logic             o_m_tlast;

    midpoint_ellipse_rasterizer_unit i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast)
    );

    // Words waiting to be sent and points waiting to come back.
    t_word  stim_q[$];
    t_point pending_points[$];

    // Handshake bookkeeping, updated once per edge by the monitor.
    int words_in    = 0;
    int words_out   = 0;
    int outstanding = 0;
    int idle_run    = 0;
    int errors      = 0;
    logic calm;

    // Predicted state of the rasterizer.
    int     col_c = 0;
    int     row_c = 0;
    int     dx_off = 0;
    int     dy_off = 0;
    longint a_sq = 0;
    longint b_sq = 0;
    longint x_term = 0;
    longint y_term = 0;
    longint dcs = 0;
    t_phase draw_ph = PH_IDLE;

    // What the run went through.
    int n_loads = 0;
    int n_points = 0;
    int n_idle = 0;
    int n_switch = 0;
    int n_ellipses = 0;

    // Neither side idles while this window of input words goes by.
    assign calm = (words_in >= 700) && (words_in < 1000);

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    task automatic report_mismatch(input string msg);
        errors++;
        if (errors <= 40) begin
            $display("ERROR: %s", msg);
        end
    endtask

    task automatic check_field(input string name, input logic [12:0] got,
                               input logic [12:0] want);
        if (got !== want) begin
            report_mismatch($sformatf("point %0d %s: got %0d want %0d", words_out, name,
                                      $signed(got), $signed(want)));
        end
    endtask

    // Midpoint ellipse walk: decision values are kept scaled by 4 so the
    // quarter and half terms stay exact.
    function automatic void trace_ellipse(input t_word w, output t_point p);
        longint ix;
        longint iy;
        p = '{default: '0};
        if (w.action == ACT_LOAD) begin
            col_c   = $signed(w.cx);
            row_c   = $signed(w.cy);
            a_sq    = longint'(w.a) * longint'(w.a);
            b_sq    = longint'(w.b) * longint'(w.b);
            dx_off  = 0;
            dy_off  = int'(w.b);
            x_term  = 0;
            y_term  = 2 * a_sq * longint'(w.b);
            dcs     = 4 * b_sq - 4 * a_sq * longint'(w.b) + a_sq;
            draw_ph = PH_R1;
            n_loads++;
            return;
        end
        if (draw_ph != PH_R1 && draw_ph != PH_R2) begin
            n_idle++;
            return;
        end
        // Slope has reached -1: restart the decision for region 2.
        if (draw_ph == PH_R1 && x_term >= y_term) begin
            ix      = 2 * dx_off + 1;
            iy      = dy_off - 1;
            dcs     = b_sq * ix * ix + 4 * a_sq * iy * iy - 4 * a_sq * b_sq;
            draw_ph = PH_R2;
            n_switch++;
        end
        p.right_col = 13'(col_c + dx_off);
        p.left_col  = 13'(col_c - dx_off);
        p.lower_row = 13'(row_c + dy_off);
        p.upper_row = 13'(row_c - dy_off);
        p.valid_res = 1'b1;
        n_points++;
        if (draw_ph == PH_R1) begin
            dx_off++;
            x_term += 2 * b_sq;
            if (dcs < 0) begin
                dcs += 4 * (x_term + b_sq);
            end else begin
                dy_off--;
                y_term -= 2 * a_sq;
                dcs += 4 * (x_term - y_term + b_sq);
            end
        end else if (dy_off == 0) begin
            p.last  = 1'b1;
            draw_ph = PH_IDLE;
            n_ellipses++;
        end else begin
            dy_off--;
            y_term -= 2 * a_sq;
            if (dcs > 0) begin
                dcs += 4 * (a_sq - y_term);
            end else begin
                dx_off++;
                x_term += 2 * b_sq;
                dcs += 4 * (x_term - y_term + a_sq);
            end
        end
    endfunction

    function automatic void queue_word(input logic act, input logic [COORD_W-1:0] cx,
                                       input logic [COORD_W-1:0] cy,
                                       input logic [AXIS_W-1:0] a,
                                       input logic [AXIS_W-1:0] b, input bit drain = 1'b0);
        stim_q.push_back('{act, cx, cy, a, b, drain});
    endfunction

    // Step words carry random payload, which the block must ignore.
    function automatic void queue_steps(input int n);
        for (int i = 0; i < n; i++) begin
            queue_word(ACT_STEP, 12'($urandom), 12'($urandom), 10'($urandom), 10'($urandom));
        end
    endfunction

    function automatic logic [COORD_W-1:0] pick_centre();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) begin
            return 12'h800;
        end else if (r == 1) begin
            return 12'h7FF;
        end
        return 12'($urandom);
    endfunction

    // Sender: presents queued words, idles at random, and holds a marked
    // word back until every earlier point has come out.
    always @(posedge i_clk) begin
        t_word nxt;
        bit    offer;
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
        end else if (!i_s_tvalid || o_s_tready) begin
            offer = 1'b0;
            if (stim_q.size() != 0 && (calm || $urandom_range(0, 99) >= 32)) begin
                offer = !stim_q[0].drain || (!i_s_tvalid && outstanding == 0);
            end
            if (offer) begin
                nxt = stim_q.pop_front();
                i_s_tvalid <= 1'b1;
                i_s_tdata  <= {4'b0, nxt.b, nxt.a, nxt.cy, nxt.cx};
                i_s_tuser  <= nxt.action;
            end else begin
                i_s_tvalid <= 1'b0;
            end
        end
    end

    // Receiver: random stalls, plus one long hold-off that backs the block up.
    int hold_left = 0;
    bit hold_done = 1'b0;
    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            hold_left  <= hold_left - 1;
            i_m_tready <= 1'b0;
        end else if (!hold_done && words_in >= 400) begin
            hold_left  <= HOLD_CYCLES;
            hold_done  <= 1'b1;
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= calm || ($urandom_range(0, 99) >= 32);
        end
    end

    // Monitor: predicts on each accepted input word, then checks each
    // accepted output word against the oldest prediction.
    always @(posedge i_clk) begin
        t_word  w;
        t_point want;
        t_point got;
        bit     in_acc;
        bit     out_acc;
        in_acc  = i_rst_n && i_s_tvalid && o_s_tready;
        out_acc = i_rst_n && o_m_tvalid && i_m_tready;
        if (in_acc) begin
            w.action = i_s_tuser;
            w.cx     = i_s_tdata[11:0];
            w.cy     = i_s_tdata[23:12];
            w.a      = i_s_tdata[33:24];
            w.b      = i_s_tdata[43:34];
            w.drain  = 1'b0;
            trace_ellipse(w, want);
            pending_points.push_back(want);
        end
        if (out_acc) begin
            got.right_col = o_m_tdata[12:0];
            got.left_col  = o_m_tdata[25:13];
            got.lower_row = o_m_tdata[38:26];
            got.upper_row = o_m_tdata[51:39];
            got.valid_res = o_m_tuser;
            got.last      = o_m_tlast;
            if (pending_points.size() == 0) begin
                report_mismatch($sformatf("point %0d arrived with nothing expected",
                                          words_out));
            end else begin
                want = pending_points.pop_front();
                check_field("right_col", got.right_col, want.right_col);
                check_field("left_col", got.left_col, want.left_col);
                check_field("lower_row", got.lower_row, want.lower_row);
                check_field("upper_row", got.upper_row, want.upper_row);
                check_field("valid_res", 13'(got.valid_res), 13'(want.valid_res));
                check_field("last", 13'(got.last), 13'(want.last));
            end
        end
        words_in    <= words_in + in_acc;
        words_out   <= words_out + out_acc;
        outstanding <= outstanding + in_acc - out_acc;
        idle_run    <= (in_acc || out_acc) ? 0 : idle_run + 1;
    end

    // Watchdog on cycles with no word moving on either side.
    initial begin
        wait (idle_run >= STALL_LIMIT);
        $display("stalled for %0d cycles with %0d points outstanding", idle_run, outstanding);
        $display("[FAIL] regression broken");
        $finish;
    end

    // Stimulus, reset and end of run.
    initial begin
        int a;
        int b;
        int n;
        int r;
        int total;
        bit drain_next;
        bit mid_drain;

        // Directed: step while idle, zero semi-axes, extreme centres and
        // axes, and a reload in the middle of an ellipse.
        queue_steps(1);
        queue_word(ACT_LOAD, 12'h000, 12'h000, 10'd5, 10'd0);
        queue_steps(2);
        queue_word(ACT_LOAD, 12'h800, 12'h7FF, 10'd0, 10'd3);
        queue_steps(4);
        queue_word(ACT_LOAD, 12'h7FF, 12'h800, 10'd0, 10'd0);
        queue_steps(1);
        queue_word(ACT_LOAD, 12'h7FF, 12'h7FF, 10'd1023, 10'd1023);
        queue_steps(3);
        queue_word(ACT_LOAD, 12'h800, 12'h800, 10'd1023, 10'd1);
        queue_steps(3);
        queue_word(ACT_LOAD, 12'hFFF, 12'h000, 10'd1, 10'd1023);
        queue_steps(2);

        // Random: mostly whole small ellipses, some cut short by a reload,
        // a few huge ones abandoned early, and stray steps between them.
        total      = 0;
        drain_next = 1'b1;
        mid_drain  = 1'b0;
        while (total < RAND_WORDS) begin
            if ($urandom_range(0, 9) == 0) begin
                queue_steps(1);
            end
            r = $urandom_range(0, 99);
            if (r < 78) begin
                a = $urandom_range(0, 24);
                b = $urandom_range(0, 24);
            end else if (r < 90) begin
                a = $urandom_range(0, 120);
                b = $urandom_range(0, 120);
            end else begin
                a = $urandom_range(0, 1023);
                b = $urandom_range(0, 1023);
            end
            queue_word(ACT_LOAD, pick_centre(), pick_centre(), 10'(a), 10'(b), drain_next);
            drain_next = 1'b0;
            n = a + b + 1;
            if (n > 250) begin
                n = $urandom_range(1, 40);
                queue_steps(n);
            end else if ($urandom_range(0, 99) < 8) begin
                n = $urandom_range(0, n);
                queue_steps(n);
            end else begin
                queue_steps(n + $urandom_range(0, 2));
            end
            total += n + 1;
            if (total >= 1200 && !mid_drain) begin
                drain_next = 1'b1;
                mid_drain  = 1'b1;
            end
        end

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        do begin
            @(negedge i_clk);
        end while (stim_q.size() != 0 || i_s_tvalid || outstanding != 0);
        repeat (16) @(posedge i_clk);
        if (pending_points.size() != 0) begin
            report_mismatch($sformatf("%0d expected points never arrived",
                                      pending_points.size()));
        end

        $display("Run: %0d words in, %0d out; %0d loads, %0d plotted points, %0d idle steps.",
                 words_in, words_out, n_loads, n_points, n_idle);
        $display("Run: %0d ellipses drawn to the last point, %0d region switches, %0d errors.",
                 n_ellipses, n_switch, errors);
        if (errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
